>>> design/tcagg_pkg.sv
// Shared widths, register indexes and result slot codes for the trade candle aggregator.
package tcagg_pkg;

    localparam int GRAN_W     = 27;
    localparam int SEQ_W      = 63;
    localparam int EXP_W      = 64;
    localparam int IN_PRICE_W = 7;
    localparam int PRICE_W    = 8;
    localparam int REP_W      = 32;
    localparam int SIDE_W     = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 63;
    localparam int SLOT_W     = 3;

    localparam logic [GRAN_W-1:0]  GRAN_RESET = GRAN_W'(60000);
    localparam logic [PRICE_W-1:0] NODATA     = 8'hFF;

    localparam logic [CFG_IDX_W-1:0] CFG_GRAN  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT  = 2'd2;

    localparam logic [SIDE_W-1:0] SIDE_YES = 2'd0;
    localparam logic [SIDE_W-1:0] SIDE_NO  = 2'd1;

    localparam logic [SLOT_W-1:0] SLOT_STATUS     = 3'd0;
    localparam logic [SLOT_W-1:0] SLOT_YES_CLOSED = 3'd1;
    localparam logic [SLOT_W-1:0] SLOT_YES_FILL   = 3'd2;
    localparam logic [SLOT_W-1:0] SLOT_NO_CLOSED  = 3'd3;
    localparam logic [SLOT_W-1:0] SLOT_NO_FILL    = 3'd4;

    typedef logic [PRICE_W-1:0] t_price;

endpackage

>>> design/trade_candle_aggregator_unit.sv
// Trade candle aggregator top level: sequence check, candle update, bucket divider, emission.
//
// Each trade item's time bucket is found by the shared restoring divider, one
// quotient bit per cycle, and its results then leave one per cycle while the
// output is not stalled. After a write to granularity_ms or start_bucket_ms,
// the next in-sequence trade also divides the live candle start, once. A
// sequence gap skips the divider. The input is ready only while the sequencer
// is idle; the last result may still wait in the output register while the
// next trade is taken. Results come in the order status, yes closed candle,
// yes filler, no closed candle, no filler. Configuration writes are always
// ready and are meant for idle periods.
module trade_candle_aggregator_unit
    import tcagg_pkg::*;
#(
    parameter int TIME_BITS = 62
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [SEQ_W-1:0]      i_sequence_id,
    input  logic [TIME_BITS-1:0]  i_trade_time_ms,
    input  logic [SIDE_W-1:0]     i_taker_side,
    input  logic [IN_PRICE_W-1:0] i_yes_price,
    input  logic [IN_PRICE_W-1:0] i_no_price,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic                  o_result_kind,
    output logic                  o_status,
    output logic                  o_candle_side,
    output logic [TIME_BITS-1:0]  o_bucket_start_ms,
    output logic [PRICE_W-1:0]    o_open_price,
    output logic [PRICE_W-1:0]    o_high_price,
    output logic [PRICE_W-1:0]    o_low_price,
    output logic [PRICE_W-1:0]    o_close_price,
    output logic [REP_W-1:0]      o_repeat_count,
    output logic                  o_last_result
);

    localparam int CNT_W = $clog2(TIME_BITS + 1);
    localparam logic [CNT_W-1:0] DIV_STEPS = CNT_W'(TIME_BITS);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CHECK = 3'd1;
    localparam logic [2:0] S_DIVS  = 3'd2;
    localparam logic [2:0] S_DIVT  = 3'd3;
    localparam logic [2:0] S_PREP  = 3'd4;
    localparam logic [2:0] S_STEP  = 3'd5;
    localparam logic [2:0] S_EMIT  = 3'd6;

    logic [2:0]            r_state;
    logic [EXP_W-1:0]      r_exp;
    logic [TIME_BITS-1:0]  r_start;
    logic [GRAN_W-1:0]     r_g;
    logic                  r_sdiv_ok;
    t_price                r_open  [2];
    t_price                r_high  [2];
    t_price                r_low   [2];
    t_price                r_close [2];

    logic [SEQ_W-1:0]      r_seq;
    logic [TIME_BITS-1:0]  r_time;
    logic [SIDE_W-1:0]     r_side;
    logic [IN_PRICE_W-1:0] r_yes;
    logic [IN_PRICE_W-1:0] r_no;

    logic [TIME_BITS-1:0]  r_dq;
    logic [GRAN_W-1:0]     r_rem;
    logic [CNT_W-1:0]      r_cnt;
    logic [TIME_BITS-1:0]  r_qs;
    logic [GRAN_W-1:0]     r_rems;
    logic [TIME_BITS-1:0]  r_qt;
    logic [GRAN_W-1:0]     r_remt;

    logic [TIME_BITS-1:0]  r_target;
    logic [TIME_BITS-1:0]  r_bkt;
    logic [TIME_BITS-1:0]  r_qdiff;
    logic [TIME_BITS-1:0]  r_next;
    logic [REP_W-1:0]      r_rep;
    logic                  r_gap;
    logic                  r_roll;
    logic                  r_fill;
    logic [SLOT_W-1:0]     r_slot;

    logic                  r_out_valid;
    logic                  r_out_kind;
    logic                  r_out_status;
    logic                  r_out_side;
    logic [TIME_BITS-1:0]  r_out_bucket;
    t_price                r_out_open;
    t_price                r_out_high;
    t_price                r_out_low;
    t_price                r_out_close;
    logic [REP_W-1:0]      r_out_rep;
    logic                  r_out_last;

    // divider step
    logic [GRAN_W:0]       trial;
    logic [GRAN_W-1:0]     trial_diff;
    logic                  trial_ge;
    logic [GRAN_W-1:0]     rem_step;
    logic [TIME_BITS-1:0]  dq_step;

    // emission
    logic                  em_side;
    logic                  fl_flat;
    logic                  n_kind;
    logic                  n_status;
    logic [TIME_BITS-1:0]  n_bucket;
    t_price                n_open;
    t_price                n_high;
    t_price                n_low;
    t_price                n_close;
    logic [REP_W-1:0]      n_rep;
    logic                  n_last;
    logic                  em_done;
    logic [SLOT_W-1:0]     n_slot;

    logic                  seq_match;
    logic [TIME_BITS-1:0]  qm1;
    logic [TIME_BITS-1:0]  g_ext;
    t_price                upd_price;
    logic                  upd_en;
    logic                  upd_side;

    assign o_cfg_ready       = 1'b1;
    assign o_in_ready        = (r_state == S_IDLE);
    assign o_out_valid       = r_out_valid;
    assign o_result_kind     = r_out_kind;
    assign o_status          = r_out_status;
    assign o_candle_side     = r_out_side;
    assign o_bucket_start_ms = r_out_bucket;
    assign o_open_price      = r_out_open;
    assign o_high_price      = r_out_high;
    assign o_low_price       = r_out_low;
    assign o_close_price     = r_out_close;
    assign o_repeat_count    = r_out_rep;
    assign o_last_result     = r_out_last;

    assign g_ext      = {{(TIME_BITS - GRAN_W){1'b0}}, r_g};
    assign trial      = {r_rem, r_dq[TIME_BITS-1]};
    assign trial_diff = trial[GRAN_W-1:0] - r_g;
    assign trial_ge   = (trial >= {1'b0, r_g});
    assign rem_step   = trial_ge ? trial_diff : trial[GRAN_W-1:0];
    assign dq_step    = {r_dq[TIME_BITS-2:0], trial_ge};

    assign seq_match  = ({1'b0, r_seq} == (r_exp + EXP_W'(1)));
    assign qm1        = r_qdiff - TIME_BITS'(1);
    assign upd_side   = (r_side == SIDE_NO);
    assign upd_en     = ((r_side == SIDE_YES) || (r_side == SIDE_NO)) && (r_time >= r_start);
    assign upd_price  = upd_side ? {1'b0, r_no} : {1'b0, r_yes};

    always_comb begin
        em_side  = (r_slot == SLOT_NO_CLOSED) || (r_slot == SLOT_NO_FILL);
        fl_flat  = (r_close[em_side] != NODATA);
        n_kind   = 1'b1;
        n_status = 1'b0;
        n_bucket = r_bkt;
        n_open   = r_open[em_side];
        n_high   = r_high[em_side];
        n_low    = r_low[em_side];
        n_close  = r_close[em_side];
        n_rep    = REP_W'(1);
        n_last   = 1'b0;
        em_done  = 1'b0;
        n_slot   = r_slot;
        unique case (r_slot) inside
            SLOT_STATUS: begin
                n_kind   = 1'b0;
                n_status = r_gap;
                n_bucket = '0;
                n_open   = '0;
                n_high   = '0;
                n_low    = '0;
                n_close  = '0;
                n_rep    = '0;
                n_last   = !r_roll;
                em_done  = !r_roll;
                n_slot   = SLOT_YES_CLOSED;
            end
            SLOT_YES_CLOSED: begin
                n_slot = r_fill ? SLOT_YES_FILL : SLOT_NO_CLOSED;
            end
            SLOT_NO_CLOSED: begin
                n_last  = !r_fill;
                em_done = !r_fill;
                n_slot  = SLOT_NO_FILL;
            end
            SLOT_YES_FILL, SLOT_NO_FILL: begin
                n_bucket = r_next;
                n_rep    = r_rep;
                if (fl_flat) begin
                    n_open = r_close[em_side];
                    n_high = r_close[em_side];
                    n_low  = r_close[em_side];
                end
                n_last  = (r_slot == SLOT_NO_FILL);
                em_done = (r_slot == SLOT_NO_FILL);
                n_slot  = SLOT_NO_CLOSED;
            end
            default: begin
                em_done = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_exp       <= '0;
            r_start     <= '0;
            r_g         <= GRAN_RESET;
            r_sdiv_ok   <= 1'b0;
            r_out_valid <= 1'b0;
            for (int s = 0; s < 2; s++) begin
                r_open[1'(s)]  <= NODATA;
                r_high[1'(s)]  <= NODATA;
                r_low[1'(s)]   <= NODATA;
                r_close[1'(s)] <= NODATA;
            end
        end else begin
            if (r_out_valid && i_out_ready && (r_state != S_EMIT)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_seq   <= i_sequence_id;
                        r_time  <= i_trade_time_ms;
                        r_side  <= i_taker_side;
                        r_yes   <= i_yes_price;
                        r_no    <= i_no_price;
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    r_slot <= SLOT_STATUS;
                    if (!seq_match) begin
                        r_exp   <= {1'b0, r_seq};
                        r_gap   <= 1'b1;
                        r_roll  <= 1'b0;
                        r_fill  <= 1'b0;
                        r_state <= S_EMIT;
                    end else begin
                        r_exp <= r_exp + EXP_W'(1);
                        r_gap <= 1'b0;
                        if (upd_en) begin
                            if (r_open[upd_side] == NODATA) begin
                                r_open[upd_side] <= upd_price;
                            end
                            if (r_high[upd_side] == NODATA || upd_price > r_high[upd_side]) begin
                                r_high[upd_side] <= upd_price;
                            end
                            if (r_low[upd_side] == NODATA || upd_price < r_low[upd_side]) begin
                                r_low[upd_side] <= upd_price;
                            end
                            r_close[upd_side] <= upd_price;
                        end
                        r_rem <= '0;
                        r_cnt <= DIV_STEPS;
                        if (r_sdiv_ok) begin
                            r_dq    <= r_time;
                            r_state <= S_DIVT;
                        end else begin
                            r_dq    <= r_start;
                            r_state <= S_DIVS;
                        end
                    end
                end
                S_DIVS: begin
                    if (r_cnt != '0) begin
                        r_dq  <= dq_step;
                        r_rem <= rem_step;
                        r_cnt <= r_cnt - CNT_W'(1);
                    end else begin
                        r_qs      <= r_dq;
                        r_rems    <= r_rem;
                        r_sdiv_ok <= 1'b1;
                        r_dq      <= r_time;
                        r_rem     <= '0;
                        r_cnt     <= DIV_STEPS;
                        r_state   <= S_DIVT;
                    end
                end
                S_DIVT: begin
                    if (r_cnt != '0) begin
                        r_dq  <= dq_step;
                        r_rem <= rem_step;
                        r_cnt <= r_cnt - CNT_W'(1);
                    end else begin
                        r_qt    <= r_dq;
                        r_remt  <= r_rem;
                        r_state <= S_PREP;
                    end
                end
                S_PREP: begin
                    r_target <= r_time - {{(TIME_BITS - GRAN_W){1'b0}}, r_remt};
                    r_bkt    <= r_start - {{(TIME_BITS - GRAN_W){1'b0}}, r_rems};
                    r_qdiff  <= r_qt - r_qs;
                    r_roll   <= (r_qs < r_qt);
                    r_state  <= S_STEP;
                end
                S_STEP: begin
                    r_fill <= r_roll && (|r_qdiff[TIME_BITS-1:1]);
                    r_next <= r_bkt + g_ext;
                    r_rep  <= (qm1 > TIME_BITS'({REP_W{1'b1}})) ? '1 : qm1[REP_W-1:0];
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out_valid  <= 1'b1;
                        r_out_kind   <= n_kind;
                        r_out_status <= n_status;
                        r_out_side   <= n_kind & em_side;
                        r_out_bucket <= n_bucket;
                        r_out_open   <= n_open;
                        r_out_high   <= n_high;
                        r_out_low    <= n_low;
                        r_out_close  <= n_close;
                        r_out_rep    <= n_rep;
                        r_out_last   <= n_last;
                        r_slot       <= n_slot;
                        if (em_done) begin
                            if (r_roll) begin
                                for (int s = 0; s < 2; s++) begin
                                    if (r_close[1'(s)] != NODATA) begin
                                        r_open[1'(s)] <= r_close[1'(s)];
                                        r_high[1'(s)] <= r_close[1'(s)];
                                        r_low[1'(s)]  <= r_close[1'(s)];
                                    end
                                end
                                r_start <= r_target;
                                r_qs    <= r_qt;
                                r_rems  <= '0;
                            end
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_GRAN: begin
                        r_g       <= (i_cfg_data[GRAN_W-1:0] == '0) ? GRAN_W'(1)
                                                                    : i_cfg_data[GRAN_W-1:0];
                        r_sdiv_ok <= 1'b0;
                    end
                    CFG_START: begin
                        r_start   <= i_cfg_data[TIME_BITS-1:0];
                        r_sdiv_ok <= 1'b0;
                    end
                    CFG_INIT: begin
                        r_exp <= {1'b0, i_cfg_data[SEQ_W-1:0]};
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

endmodule

>>> tb/trade_candle_aggregator_unit_test.sv
// Self-checking testbench for the trade candle aggregator: directed table, then random phases.
module trade_candle_aggregator_unit_test;
    import tcagg_pkg::*;

    localparam int TIME_W        = 62;
    localparam int SETTLE_CYCLES = 2 * TIME_W + 40;
    localparam int HOLD_CYCLES   = 600;
    localparam int DRAIN_LIMIT   = 20000;
    localparam int LIMIT_CYCLES  = 600000;

    localparam logic KIND_STATUS = 1'b0;
    localparam logic KIND_CANDLE = 1'b1;
    localparam logic ST_OK       = 1'b0;
    localparam logic ST_GAP      = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
    localparam logic [TIME_W-1:0]    TIME_MAX  = '1;
    localparam logic [SEQ_W-1:0]     SEQ_MAX   = '1;

    typedef struct packed {
        logic [SEQ_W-1:0]      seq;
        logic [TIME_W-1:0]     t;
        logic [SIDE_W-1:0]     side;
        logic [IN_PRICE_W-1:0] yes_px;
        logic [IN_PRICE_W-1:0] no_px;
    } t_trade;

    typedef struct packed {
        logic              kind;
        logic              status;
        logic              side;
        logic [TIME_W-1:0] bucket;
        t_price            px_open;
        t_price            px_high;
        t_price            px_low;
        t_price            px_close;
        logic [REP_W-1:0]  rep;
        logic              last;
    } t_result;

    typedef enum logic [1:0] {CHK_MODEL, CHK_OK, CHK_GAP} t_check;

    typedef struct {
        bit                    is_reg;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
        t_trade                tr;
        t_check                chk;
    } t_row;

    localparam t_result GAP_ONLY = '{kind: KIND_STATUS, status: ST_GAP, last: 1'b1, default: '0};
    localparam t_result OK_ONLY  = '{kind: KIND_STATUS, status: ST_OK, last: 1'b1, default: '0};

    logic                  i_clk           = 1'b0;
    logic                  i_rst_n         = 1'b0;
    logic                  i_cfg_valid     = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index     = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data      = '0;
    logic                  i_in_valid      = 1'b0;
    logic                  o_in_ready;
    logic [SEQ_W-1:0]      i_sequence_id   = '0;
    logic [TIME_W-1:0]     i_trade_time_ms = '0;
    logic [SIDE_W-1:0]     i_taker_side    = '0;
    logic [IN_PRICE_W-1:0] i_yes_price     = '0;
    logic [IN_PRICE_W-1:0] i_no_price      = '0;
    logic                  o_out_valid;
    logic                  i_out_ready     = 1'b0;
    logic                  o_result_kind;
    logic                  o_status;
    logic                  o_candle_side;
    logic [TIME_W-1:0]     o_bucket_start_ms;
    logic [PRICE_W-1:0]    o_open_price;
    logic [PRICE_W-1:0]    o_high_price;
    logic [PRICE_W-1:0]    o_low_price;
    logic [PRICE_W-1:0]    o_close_price;
    logic [REP_W-1:0]      o_repeat_count;
    logic                  o_last_result;

    trade_candle_aggregator_unit #(.TIME_BITS(TIME_W)) u_dut (.*);

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // candle book mirror
    logic [GRAN_W-1:0] gran_q;
    logic [EXP_W-1:0]  last_seq;
    logic [TIME_W-1:0] cstart [2];
    t_price            c_open [2];
    t_price            c_high [2];
    t_price            c_low [2];
    t_price            c_close [2];
    t_result           step_out[$];
    t_result           due_results[$];
    t_row              plan[$];

    int snd_idle   = 32;
    int rcv_idle   = 48;
    bit hold_req   = 1'b0;
    bit hold_ack   = 1'b0;
    int hold_left  = 0;
    int n_cycles   = 0;
    int n_bad      = 0;
    int n_trades   = 0;
    int n_checked  = 0;
    int n_candles  = 0;
    int n_gaps     = 0;
    int n_writes   = 0;

    function automatic void reset_book();
        gran_q   = GRAN_RESET;
        last_seq = '0;
        for (int s = 0; s < 2; s++) begin
            cstart[s]  = '0;
            c_open[s]  = NODATA;
            c_high[s]  = NODATA;
            c_low[s]   = NODATA;
            c_close[s] = NODATA;
        end
    endfunction

    function automatic logic [63:0] eff_gran();
        return (gran_q == '0) ? 64'd1 : 64'(gran_q);
    endfunction

    function automatic logic [63:0] floor_bucket(input logic [63:0] t);
        logic [63:0] g;
        g = eff_gran();
        return (t / g) * g;
    endfunction

    function automatic void load_reg(input logic [CFG_IDX_W-1:0] idx,
                                     input logic [CFG_DATA_W-1:0] d);
        case (idx)
            CFG_GRAN: gran_q = d[GRAN_W-1:0];
            CFG_START: begin
                cstart[0] = d[TIME_W-1:0];
                cstart[1] = d[TIME_W-1:0];
            end
            CFG_INIT: last_seq = {1'b0, d};
            default: ;
        endcase
    endfunction

    function automatic void fold_price(input int s, input logic [TIME_W-1:0] t, input t_price p);
        if (t < cstart[s]) return;
        if (c_open[s] == NODATA) c_open[s] = p;
        if (c_high[s] == NODATA || p > c_high[s]) c_high[s] = p;
        if (c_low[s] == NODATA || p < c_low[s]) c_low[s] = p;
        c_close[s] = p;
    endfunction

    function automatic void close_side(input int s, input logic [63:0] target);
        logic [63:0] g;
        logic [63:0] nxt;
        logic [63:0] cnt;
        t_result     r;
        if (64'(cstart[s]) >= target) return;
        g = eff_gran();
        r = '0;
        r.kind     = KIND_CANDLE;
        r.side     = 1'(s);
        r.bucket   = TIME_W'(floor_bucket(64'(cstart[s])));
        r.px_open  = c_open[s];
        r.px_high  = c_high[s];
        r.px_low   = c_low[s];
        r.px_close = c_close[s];
        r.rep      = REP_W'(1);
        step_out.push_back(r);
        if (c_close[s] != NODATA) begin
            c_open[s] = c_close[s];
            c_high[s] = c_close[s];
            c_low[s]  = c_close[s];
        end
        nxt = floor_bucket(64'(cstart[s]) + g);
        if (nxt < target) begin
            cnt        = (target - nxt) / g;
            r.bucket   = TIME_W'(nxt);
            r.px_open  = c_open[s];
            r.px_high  = c_high[s];
            r.px_low   = c_low[s];
            r.px_close = c_close[s];
            r.rep      = (cnt > 64'hFFFF_FFFF) ? '1 : cnt[REP_W-1:0];
            step_out.push_back(r);
            nxt = target;
        end
        cstart[s] = TIME_W'(nxt);
    endfunction

    function automatic void trade_to_candles(input t_trade tr);
        logic [63:0] target;
        step_out.delete();
        if (64'(tr.seq) != last_seq + 64'd1) begin
            last_seq = 64'(tr.seq);
            step_out.push_back(GAP_ONLY);
            return;
        end
        last_seq = last_seq + 64'd1;
        if (tr.side == SIDE_YES) fold_price(0, tr.t, PRICE_W'(tr.yes_px));
        else if (tr.side == SIDE_NO) fold_price(1, tr.t, PRICE_W'(tr.no_px));
        step_out.push_back(OK_ONLY);
        target = floor_bucket(64'(tr.t));
        close_side(0, target);
        close_side(1, target);
        foreach (step_out[i]) step_out[i].last = (i == step_out.size() - 1);
    endfunction

    task automatic plan_trade(input logic [SEQ_W-1:0] seq, input logic [TIME_W-1:0] t,
                              input logic [SIDE_W-1:0] side, input logic [IN_PRICE_W-1:0] yp,
                              input logic [IN_PRICE_W-1:0] np, input t_check chk);
        t_row r;
        r.is_reg = 1'b0;
        r.idx    = '0;
        r.data   = '0;
        r.tr     = '{seq: seq, t: t, side: side, yes_px: yp, no_px: np};
        r.chk    = chk;
        plan.push_back(r);
    endtask

    task automatic plan_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
        t_row r;
        r.is_reg = 1'b1;
        r.idx    = idx;
        r.data   = d;
        r.tr     = '0;
        r.chk    = CHK_MODEL;
        plan.push_back(r);
    endtask

    task automatic sender_pause();
        while ($urandom_range(99) < snd_idle) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    task automatic offer_trade(input t_trade tr, input t_check chk);
        i_in_valid      <= 1'b1;
        i_sequence_id   <= tr.seq;
        i_trade_time_ms <= tr.t;
        i_taker_side    <= tr.side;
        i_yes_price     <= tr.yes_px;
        i_no_price      <= tr.no_px;
        do @(posedge i_clk); while (!(i_in_valid && o_in_ready));
        trade_to_candles(tr);
        case (chk)
            CHK_GAP: due_results.push_back(GAP_ONLY);
            CHK_OK:  due_results.push_back(OK_ONLY);
            default: foreach (step_out[i]) due_results.push_back(step_out[i]);
        endcase
        n_trades++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= d;
        do @(posedge i_clk); while (!(i_cfg_valid && o_cfg_ready));
        load_reg(idx, d);
        n_writes++;
    endtask

    task automatic settle();
        i_in_valid <= 1'b0;
        while (due_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic run_phase(input int n, input logic [GRAN_W-1:0] g,
                             input logic [TIME_W-1:0] st, input logic [SEQ_W-1:0] init,
                             input int s_idle, input int r_idle, input bit squeeze);
        logic [63:0] ge;
        logic [63:0] now;
        logic [63:0] t;
        t_trade      tr;
        int          r;
        settle();
        snd_idle = s_idle;
        rcv_idle = r_idle;
        write_reg(CFG_GRAN, CFG_DATA_W'(g));
        write_reg(CFG_START, CFG_DATA_W'(st));
        write_reg(CFG_INIT, init);
        i_cfg_valid <= 1'b0;
        ge  = (g == '0) ? 64'd1 : 64'(g);
        now = 64'(st);
        for (int k = 0; k < n; k++) begin
            if (squeeze && k == n / 4) hold_req = ~hold_req;
            r = $urandom_range(99);
            if (r < 85) tr.seq = SEQ_W'(last_seq + 64'd1);
            else if (r < 90) tr.seq = last_seq[SEQ_W-1:0];
            else if (r < 95) tr.seq = SEQ_W'({$urandom, $urandom});
            else tr.seq = SEQ_W'(last_seq + 64'd2);
            r = $urandom_range(99);
            if (k >= n - 2) t = 64'(TIME_MAX) - $urandom_range(0, 5000);
            else if (r < 55) t = now + $urandom_range(0, 32'(ge / 2));
            else if (r < 80) t = now + ge * $urandom_range(1, 4) + $urandom_range(0, 32'(ge - 1));
            else if (r < 90) t = (now > 3 * ge) ? now - $urandom_range(0, 32'(3 * ge)) : 64'd0;
            else if (r < 96) t = now + ge * $urandom_range(5, 40);
            else t = now + {$urandom_range(0, 255), $urandom};
            if (t > now) now = t;
            tr.t = TIME_W'(t);
            r = $urandom_range(99);
            if (r < 45) tr.side = SIDE_YES;
            else if (r < 90) tr.side = SIDE_NO;
            else tr.side = SIDE_W'($urandom_range(2, 3));
            tr.yes_px = IN_PRICE_W'($urandom_range(0, 127));
            tr.no_px  = IN_PRICE_W'($urandom_range(0, 127));
            sender_pause();
            offer_trade(tr, CHK_MODEL);
        end
    endtask

    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                got = {o_result_kind, o_status, o_candle_side, o_bucket_start_ms, o_open_price,
                       o_high_price, o_low_price, o_close_price, o_repeat_count, o_last_result};
                n_checked++;
                if (due_results.size() == 0) begin
                    n_bad++;
                    if (n_bad <= 10)
                        $display("unexpected result: kind=%0d st=%0d side=%0d start=%0d rep=%0d",
                                 got.kind, got.status, got.side, got.bucket, got.rep);
                end else begin
                    want = due_results.pop_front();
                    if (got !== want) begin
                        n_bad++;
                        if (n_bad <= 10) begin
                            $display({"mismatch %0d exp: kind=%0d st=%0d side=%0d start=%0d",
                                      " ohlc=%0d/%0d/%0d/%0d rep=%0d last=%0d"},
                                     n_bad, want.kind, want.status, want.side, want.bucket,
                                     want.px_open, want.px_high, want.px_low, want.px_close,
                                     want.rep, want.last);
                            $display({"           got: kind=%0d st=%0d side=%0d start=%0d",
                                      " ohlc=%0d/%0d/%0d/%0d rep=%0d last=%0d"},
                                     got.kind, got.status, got.side, got.bucket,
                                     got.px_open, got.px_high, got.px_low, got.px_close,
                                     got.rep, got.last);
                        end
                    end
                    if (want.kind == KIND_CANDLE) n_candles++;
                    else if (want.status == ST_GAP) n_gaps++;
                end
            end
            if (hold_req != hold_ack) begin
                hold_ack    <= hold_req;
                hold_left   <= HOLD_CYCLES;
                i_out_ready <= 1'b0;
            end else if (hold_left != 0) begin
                hold_left   <= hold_left - 1;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= ($urandom_range(99) >= rcv_idle);
            end
        end
    end

    always @(posedge i_clk) begin
        n_cycles <= n_cycles + 1;
        if (n_cycles == LIMIT_CYCLES) begin
            $display("timeout after %0d cycles, %0d results outstanding", n_cycles,
                     due_results.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        reset_book();
        plan_trade(1, 0, SIDE_YES, 50, 0, CHK_OK);
        plan_trade(5, 123, SIDE_NO, 3, 4, CHK_GAP);
        plan_trade(6, 59999, SIDE_NO, 0, 100, CHK_OK);
        plan_trade(7, 60000, 2'd2, 127, 127, CHK_MODEL);
        plan_trade(8, 240005, 2'd3, 1, 2, CHK_MODEL);
        plan_trade(9, 0, SIDE_YES, 10, 10, CHK_OK);
        plan_trade(10, 240010, SIDE_YES, 0, 9, CHK_OK);
        plan_trade(11, 240011, SIDE_NO, 64, 127, CHK_OK);
        plan_reg(CFG_GRAN, '0);
        plan_reg(CFG_START, 12345);
        plan_reg(CFG_INIT, SEQ_MAX);
        plan_reg(CFG_SPARE, '1);
        plan_trade(0, 5, SIDE_YES, 1, 1, CHK_GAP);
        plan_trade(1, 12346, SIDE_YES, 100, 33, CHK_MODEL);
        plan_trade(2, TIME_MAX, SIDE_NO, 21, 1, CHK_MODEL);
        plan_reg(CFG_GRAN, '1);
        plan_reg(CFG_START, 12345);
        plan_reg(CFG_INIT, SEQ_MAX - 1);
        plan_trade(SEQ_MAX, 402653188, SIDE_YES, 0, 90, CHK_MODEL);
        plan_trade(0, 402653188, SIDE_NO, 5, 5, CHK_GAP);
        plan_trade(1, 402653193, SIDE_NO, 77, 0, CHK_OK);

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (plan[i]) begin
            if (plan[i].is_reg) begin
                if (i == 0 || !plan[i-1].is_reg) settle();
                write_reg(plan[i].idx, plan[i].data);
            end else begin
                if (i > 0 && plan[i-1].is_reg) i_cfg_valid <= 1'b0;
                sender_pause();
                offer_trade(plan[i].tr, plan[i].chk);
            end
        end

        run_phase(81, GRAN_W'($urandom_range(1, 5000)), TIME_W'($urandom_range(0, 1000000)),
                  SEQ_W'({$urandom, $urandom}), 32, 48, 1'b0);
        run_phase(81, GRAN_W'(86400000), TIME_W'({$urandom_range(0, 65535), $urandom}),
                  SEQ_W'({$urandom, $urandom}), 48, 32, 1'b0);
        run_phase(81, GRAN_W'($urandom_range(1, 64)), '0, SEQ_MAX - 30, 0, 0, 1'b1);

        i_in_valid <= 1'b0;
        for (int w = 0; w < DRAIN_LIMIT && due_results.size() != 0; w++) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (due_results.size() != 0) begin
            $display("%0d expected results never arrived", due_results.size());
            n_bad += due_results.size();
        end

        $display("%0d trades (%0d sequence gaps), %0d results checked, %0d candles, %0d writes",
                 n_trades, n_gaps, n_checked, n_candles, n_writes);
        $display("directed table, three random phases, a %0d-cycle output hold; %0d errors",
                 HOLD_CYCLES, n_bad);
        if (n_bad == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
